// File: rtl/core/dghp_pkg.sv
// Shared types and constants of the data group header parser.
package dghp_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] TID_ABSENT = 16'hFFFF;
   localparam logic [3:0]  EXT_SKIP   = 4'd2;
   localparam logic [3:0]  TID_MIN_LEN = 4'd2;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_CONT,
      PH_EXT,
      PH_SESS_HI,
      PH_SESS_LO,
      PH_UACC,
      PH_UFIELD,
      PH_SIZE_HI,
      PH_SIZE_LO,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic ext;
      logic crc;
      logic sess;
      logic user;
   } flags_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       group_start;
      logic       group_end;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic        end_of_payload;
      logic [2:0]  group_type;
      logic        ext_present;
      logic        crc_present;
      logic        session_present;
      logic        last_segment;
      logic [14:0] segment_number;
      logic [15:0] transport_id;
      logic [12:0] segment_size;
   } rsp_type;

   // One queued operation: a finished result, or a payload byte that still
   // has to pass the two-byte CRC delay.
   typedef struct packed {
      logic    delay;
      rsp_type rsp;
   } entry_type;

endpackage

// File: rtl/core/dghp_front.sv
// Header parsing state machine that turns input bytes into queued operations.
module dghp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  dghp_pkg::req_type   in_req,
   output logic                push,
   output dghp_pkg::entry_type push_entry
);
   import dghp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  skip_ff, skip_in;
   flags_type   flags_ff, flags_in;
   logic [2:0]  gtype_ff, gtype_in;
   logic [3:0]  ulen_ff, ulen_in;
   logic [14:0] segnum_ff, segnum_in;
   logic        last_ff, last_in;
   logic [15:0] tid_ff, tid_in;
   logic [4:0]  size_hi_ff, size_hi_in;
   logic        tidcap_ff, tidcap_in;

   logic [7:0]  b;
   logic        st;
   logic        en;
   logic        parsing;
   logic [3:0]  idx;

   assign b   = in_req.data_byte;
   assign st  = in_req.group_start;
   assign en  = in_req.group_end;
   assign idx = ulen_ff - skip_ff;
   assign parsing = phase_ff inside {PH_CONT, PH_EXT, PH_SESS_HI, PH_SESS_LO,
                                     PH_UACC, PH_UFIELD, PH_SIZE_HI};

   function automatic phase_type after_session(input flags_type f);
      return f.user ? PH_UACC : PH_SIZE_HI;
   endfunction

   function automatic phase_type after_ext(input flags_type f);
      return f.sess ? PH_SESS_HI : after_session(f);
   endfunction

   // Next state.
   always_comb begin
      phase_in   = phase_ff;
      skip_in    = skip_ff;
      flags_in   = flags_ff;
      gtype_in   = gtype_ff;
      ulen_in    = ulen_ff;
      segnum_in  = segnum_ff;
      last_in    = last_ff;
      tid_in     = tid_ff;
      size_hi_in = size_hi_ff;
      tidcap_in  = tidcap_ff;
      if (in_valid) begin
         if (st) begin
            skip_in    = '0;
            flags_in   = flags_type'(b[7:4]);
            gtype_in   = b[2:0];
            ulen_in    = '0;
            segnum_in  = '0;
            last_in    = 1'b0;
            tid_in     = TID_ABSENT;
            size_hi_in = '0;
            tidcap_in  = 1'b0;
            phase_in   = en ? PH_IDLE : PH_CONT;
         end else begin
            case (phase_ff)
               PH_CONT: begin
                  if (flags_ff.ext) begin
                     phase_in = PH_EXT;
                     skip_in  = EXT_SKIP;
                  end else begin
                     phase_in = after_ext(flags_ff);
                  end
               end
               PH_EXT: begin
                  skip_in = skip_ff - 4'd1;
                  if (skip_ff == 4'd1) begin
                     phase_in = after_ext(flags_ff);
                  end
               end
               PH_SESS_HI: begin
                  last_in   = b[7];
                  segnum_in = {b[6:0], 8'h00};
                  phase_in  = PH_SESS_LO;
               end
               PH_SESS_LO: begin
                  segnum_in = segnum_ff | {7'd0, b};
                  phase_in  = after_session(flags_ff);
               end
               PH_UACC: begin
                  ulen_in   = b[3:0];
                  tidcap_in = b[4] && (b[3:0] >= TID_MIN_LEN);
                  skip_in   = b[3:0];
                  phase_in  = (b[3:0] != 4'd0) ? PH_UFIELD : PH_SIZE_HI;
               end
               PH_UFIELD: begin
                  if (tidcap_ff && idx == 4'd0) begin
                     tid_in = {b, 8'hFF};
                  end else if (tidcap_ff && idx == 4'd1) begin
                     tid_in = {tid_ff[15:8], b};
                  end
                  skip_in = skip_ff - 4'd1;
                  if (skip_ff == 4'd1) begin
                     phase_in = PH_SIZE_HI;
                  end
               end
               PH_SIZE_HI: begin
                  size_hi_in = b[4:0];
                  phase_in   = PH_SIZE_LO;
               end
               PH_SIZE_LO: begin
                  phase_in = en ? PH_IDLE : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  if (en) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            // A group that ends inside its header is cut short.
            if (en && parsing) begin
               phase_in = PH_IDLE;
            end
         end
      end
   end

   // Outputs toward the queue.
   always_comb begin
      push       = 1'b0;
      push_entry = '0;
      if (in_valid && en && (st || parsing)) begin
         push                = 1'b1;
         push_entry.rsp.kind = KIND_ERROR;
      end else if (in_valid && !st && phase_ff == PH_SIZE_LO) begin
         push                           = 1'b1;
         push_entry.rsp.kind            = KIND_HEADER;
         push_entry.rsp.group_type      = gtype_ff;
         push_entry.rsp.ext_present     = flags_ff.ext;
         push_entry.rsp.crc_present     = flags_ff.crc;
         push_entry.rsp.session_present = flags_ff.sess;
         push_entry.rsp.last_segment    = last_ff;
         push_entry.rsp.segment_number  = segnum_ff;
         push_entry.rsp.transport_id    = tid_ff;
         push_entry.rsp.segment_size    = {size_hi_ff, b};
      end else if (in_valid && !st && phase_ff == PH_PAYLOAD) begin
         push                          = 1'b1;
         push_entry.delay              = flags_ff.crc;
         push_entry.rsp.kind           = KIND_PAYLOAD;
         push_entry.rsp.payload_byte   = b;
         push_entry.rsp.end_of_payload = en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      skip_ff    <= skip_in;
      flags_ff   <= flags_in;
      gtype_ff   <= gtype_in;
      ulen_ff    <= ulen_in;
      segnum_ff  <= segnum_in;
      last_ff    <= last_in;
      tid_ff     <= tid_in;
      size_hi_ff <= size_hi_in;
      tidcap_ff  <= tidcap_in;
   end

endmodule

// File: rtl/core/dghp_queue.sv
// Short first-in first-out queue of operations between front and back.
module dghp_queue #(
   parameter int DEPTH = dghp_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dghp_pkg::entry_type push_entry,
   input  logic                pop,
   output dghp_pkg::entry_type head,
   output logic                head_valid,
   output logic                full
);
   import dghp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   entry_type       slot_ff [DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == FULL_COUNT);
   assign head       = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/core/dghp_back.sv
// CRC tail delay and registered result stage.
module dghp_back (
   input  logic                clock,
   input  logic                reset,
   input  dghp_pkg::entry_type head,
   input  logic                head_valid,
   output logic                take,
   output dghp_pkg::rsp_type   rsp_data,
   output logic                rsp_empty,
   input  logic                rsp_pop
);
   import dghp_pkg::*;

   logic [7:0] dly_ff [2];
   logic [7:0] dly_in [2];
   logic [1:0] fill_ff, fill_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       slot_free;
   logic       hold;
   logic       emit;

   assign slot_free = !out_valid_ff || rsp_pop;
   // A delayed byte is held back without a result while the delay line is still filling.
   assign hold = head.delay && (fill_ff < 2'd2);
   assign take = head_valid && (hold || slot_free);
   assign emit = head_valid && !hold && slot_free;

   always_comb begin
      dly_in[0]    = dly_ff[0];
      dly_in[1]    = dly_ff[1];
      fill_in      = fill_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (take && head.delay) begin
         if (hold) begin
            dly_in[fill_ff[0]] = head.rsp.payload_byte;
            fill_in            = fill_ff + 2'd1;
         end else begin
            dly_in[0] = dly_ff[1];
            dly_in[1] = head.rsp.payload_byte;
         end
      end
      if (take && head.rsp.kind == KIND_HEADER) begin
         fill_in = '0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = head.rsp;
         if (head.delay) begin
            out_in.payload_byte = dly_ff[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
      dly_ff[0] <= dly_in[0];
      dly_ff[1] <= dly_in[1];
      out_ff    <= out_in;
   end

   assign rsp_data  = out_ff;
   assign rsp_empty = !out_valid_ff;

endmodule

// File: rtl/core/data_group_header_parser.sv
// Top level of the data group header parser.
//
//   channel   direction  handshake             payload
//   req_      in         req_push / req_full   req_data  (data byte, start and end marks)
//   rsp_      out        rsp_empty / rsp_pop   rsp_data  (header, payload byte or error)
//
// One byte is taken every cycle while req_full is low; each byte gives at most one result.
// A result reaches the rsp_ ports through the queue and the output register: the parser is
// combinational and writes the operation into the queue at its byte's transfer edge, and the
// output register takes it from the queue head once the output slot is free.
// A synchronous reset clears the parse state, queue pointers, delay fill and output valid.
// A stalled result side fills the queue, which then raises req_full; the two sides
// otherwise run independently.
module data_group_header_parser #(
   parameter int QUEUE_DEPTH = dghp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  dghp_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output dghp_pkg::rsp_type rsp_data
);
   import dghp_pkg::*;

   logic      in_valid;
   logic      push;
   entry_type push_entry;
   entry_type head;
   logic      head_valid;
   logic      take;

   // A byte transfer happens when req_push is high and the queue has room for an operation.
   assign in_valid = req_push && !req_full;

   // The front parses the header fields and classifies each byte that gives an operation as a
   // header result, an error, a plain payload byte or a payload byte bound for the CRC delay.
   dghp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid),
      .in_req     (req_data),
      .push       (push),
      .push_entry (push_entry)
   );

   dghp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (take),
      .head       (head),
      .head_valid (head_valid),
      .full       (req_full)
   );

   // The back runs the two-byte delay that drops the CRC and holds the result register.
   dghp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .take       (take),
      .rsp_data   (rsp_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop)
   );

endmodule
